@@ rtl/core/amnq_pkg.sv @@
// Shared types and constants for the adjacency-matrix neighbour query block.
`timescale 1ns / 1ps
package amnq_pkg;

	localparam int VTX_W   = 4;
	localparam int CMD_W   = 2;
	localparam int VTX_MAX = 1 << VTX_W;
	localparam int Q_DEPTH = 2;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LIST   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMMON = 2'd2;

	// work kinds handed from the front to the back
	typedef enum logic [1:0] {
		OP_ADD,
		OP_LIST,
		OP_COMMON,
		OP_EMPTY
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
	} task_t;

endpackage

@@ rtl/core/amnq_req_if.sv @@
// Request channel: command and two vertex fields with valid/ready.
`timescale 1ns / 1ps
interface amnq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [3:0] vertex_a;
	logic [3:0] vertex_b;

	modport source (output valid, output cmd, output vertex_a, output vertex_b, input ready);
	modport sink   (input valid, input cmd, input vertex_a, input vertex_b, output ready);
endinterface

@@ rtl/core/amnq_res_if.sv @@
// Result channel: neighbour index, found and last flags with valid/ready.
`timescale 1ns / 1ps
interface amnq_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] neighbor;
	logic       found;
	logic       last;

	modport source (output valid, output neighbor, output found, output last, input ready);
	modport sink   (input valid, input neighbor, input found, input last, output ready);
endinterface

@@ rtl/core/amnq_front.sv @@
// Front end: takes requests, range-checks vertices and classifies the work.
`timescale 1ns / 1ps
module amnq_front #(
	parameter int VCOUNT = 16
) (
	amnq_req_if.sink        req,
	output logic            push_valid,
	input  logic            push_ready,
	output amnq_pkg::task_t push_data
);
	import amnq_pkg::*;

	logic a_ok;
	logic b_ok;
	logic keep;
	op_t  op;

	assign a_ok = {1'b0, req.vertex_a} < (VTX_W+1)'(VCOUNT);
	assign b_ok = {1'b0, req.vertex_b} < (VTX_W+1)'(VCOUNT);

	// add-edge with a bad vertex and the unused code are swallowed here
	always_comb begin
		keep = 1'b0;
		op   = OP_EMPTY;
		case (req.cmd)
			CMD_ADD: begin
				keep = a_ok && b_ok;
				op   = OP_ADD;
			end
			CMD_LIST: begin
				keep = 1'b1;
				op   = a_ok ? OP_LIST : OP_EMPTY;
			end
			CMD_COMMON: begin
				keep = 1'b1;
				op   = (a_ok && b_ok) ? OP_COMMON : OP_EMPTY;
			end
			default: begin
				keep = 1'b0;
				op   = OP_EMPTY;
			end
		endcase
	end

	assign req.ready    = push_ready;
	assign push_valid   = req.valid && keep;
	assign push_data.op = op;
	assign push_data.a  = req.vertex_a;
	assign push_data.b  = req.vertex_b;

endmodule

@@ rtl/core/amnq_queue.sv @@
// Short FIFO of classified work between front and back.
`timescale 1ns / 1ps
module amnq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  amnq_pkg::task_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output amnq_pkg::task_t pop_data
);
	import amnq_pkg::*;

	localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW = $clog2(Q_DEPTH + 1);

	task_t           slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = cnt_q != Q_CW'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CW'(Q_DEPTH))
		else $error("queue count above depth");

endmodule

@@ rtl/core/amnq_back.sv @@
// Back end: adjacency row memory, edge insertion and ordered neighbour emission.
`timescale 1ns / 1ps
module amnq_back #(
	parameter int VCOUNT = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  amnq_pkg::task_t pop_data,
	amnq_res_if.source      res
);
	import amnq_pkg::*;

	localparam int ROW_AW = (VCOUNT > 1) ? $clog2(VCOUNT) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRB,
		ST_EMIT
	} state_t;

	state_t            state_q;
	task_t             cur_q;
	logic [VCOUNT-1:0] pend_q;
	logic [VCOUNT-1:0] vld_q;
	logic              rd_a_vld_q;
	logic              rd_b_vld_q;
	logic              res_valid_q;
	logic [VTX_W-1:0]  res_nb_q;
	logic              res_found_q;
	logic              res_last_q;

	logic [VCOUNT-1:0] mem_q [VCOUNT];
	logic [VCOUNT-1:0] rd_a_raw_q;
	logic [VCOUNT-1:0] rd_b_raw_q;

	logic [ROW_AW-1:0] pop_a;
	logic [ROW_AW-1:0] pop_b;
	logic [ROW_AW-1:0] cur_a;
	logic [ROW_AW-1:0] cur_b;
	logic              do_pop;
	logic [VCOUNT-1:0] rd_a;
	logic [VCOUNT-1:0] rd_b;
	logic [VCOUNT-1:0] oh_a;
	logic [VCOUNT-1:0] oh_b;
	logic [VCOUNT-1:0] qmask;
	logic [VCOUNT-1:0] low_bit;
	logic [VCOUNT-1:0] pend_nxt;
	logic [ROW_AW-1:0] low_idx;
	logic              slot_free;
	logic              res_load;
	logic              mem_we;
	logic [ROW_AW-1:0] mem_waddr;
	logic [VCOUNT-1:0] mem_wdata;

	assign pop_a     = pop_data.a[ROW_AW-1:0];
	assign pop_b     = pop_data.b[ROW_AW-1:0];
	assign cur_a     = cur_q.a[ROW_AW-1:0];
	assign cur_b     = cur_q.b[ROW_AW-1:0];
	assign pop_ready = state_q == ST_IDLE;
	assign do_pop    = pop_valid && pop_ready;
	assign slot_free = !res_valid_q || res.ready;
	// a new result goes into the output register this cycle
	assign res_load  = state_q == ST_EMIT && slot_free;

	// rows never written read as empty
	assign rd_a = rd_a_vld_q ? rd_a_raw_q : '0;
	assign rd_b = rd_b_vld_q ? rd_b_raw_q : '0;
	assign oh_a = VCOUNT'(1) << cur_a;
	assign oh_b = VCOUNT'(1) << cur_b;

	always_comb begin
		qmask = rd_a & ~oh_a;
		if (cur_q.op == OP_COMMON) begin
			qmask = qmask & rd_b & ~oh_b;
		end
	end

	// lowest pending vertex
	assign low_bit  = pend_q & (~pend_q + VCOUNT'(1));
	assign pend_nxt = pend_q & ~low_bit;

	always_comb begin
		low_idx = '0;
		for (int i = 0; i < VCOUNT; i++) begin
			if (low_bit[i]) begin
				low_idx = low_idx | ROW_AW'(i);
			end
		end
	end

	// edge insert: row a in the read cycle, row b in the cycle after it
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_a;
		mem_wdata = rd_a | oh_b;
		if (state_q == ST_READ && cur_q.op == OP_ADD) begin
			mem_we = 1'b1;
		end else if (state_q == ST_WRB) begin
			mem_we    = 1'b1;
			mem_waddr = cur_b;
			mem_wdata = rd_b | oh_a;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (do_pop) begin
			rd_a_raw_q <= mem_q[pop_a];
			rd_b_raw_q <= mem_q[pop_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			pend_q      <= '0;
			vld_q       <= '0;
			rd_a_vld_q  <= 1'b0;
			rd_b_vld_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_nb_q    <= '0;
			res_found_q <= 1'b0;
			res_last_q  <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						cur_q      <= pop_data;
						rd_a_vld_q <= vld_q[pop_a];
						rd_b_vld_q <= vld_q[pop_b];
						if (pop_data.op == OP_EMPTY) begin
							pend_q  <= '0;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (cur_q.op == OP_ADD) begin
						state_q <= ST_WRB;
					end else begin
						pend_q  <= qmask;
						state_q <= ST_EMIT;
					end
				end
				ST_WRB: begin
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						if (pend_q == '0) begin
							res_nb_q    <= '0;
							res_found_q <= 1'b0;
							res_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							res_nb_q    <= VTX_W'(low_idx);
							res_found_q <= 1'b1;
							res_last_q  <= pend_nxt == '0;
							pend_q      <= pend_nxt;
							if (pend_nxt == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid    = res_valid_q;
	assign res.neighbor = res_nb_q;
	assign res.found    = res_found_q;
	assign res.last     = res_last_q;

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_found_q |-> res_last_q)
		else $error("empty answer not marked last");

	a_no_self: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && cur_q.op != OP_EMPTY |-> !pend_q[cur_a])
		else $error("query vertex pending for emission");

	a_wrb_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRB |=> state_q == ST_IDLE)
		else $error("second edge write did not finish");

	a_write_add_only: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> cur_q.op == OP_ADD)
		else $error("row write outside edge insert");

endmodule

@@ rtl/core/adjacency_matrix_neighbor_query_top.sv @@
// Top level of the adjacency-matrix neighbour query block.
`timescale 1ns / 1ps
//
// Channel | Dir | Payload                      | Handshake
// --------+-----+------------------------------+-----------
// req     | in  | cmd, vertex_a, vertex_b      | valid/ready
// res     | out | neighbor, found, last        | valid/ready
//
// Add-edge: the back end pops, writes row a, then writes row b.
// Query: pop and read the two rows, then one result per cycle while the result
//   register is free (empty or res ready); rows come through a registered read
//   and results leave through the single result register.
// Reset clears all rows (per-row valid flags), the queue and the result register.
// A two-entry queue parts request acceptance from the back end; either side stalls alone.
// Unused command code and add-edge with an out-of-range vertex are taken and dropped.
//
module adjacency_matrix_neighbor_query_top #(
	parameter int NUM_VERTICES = 16
) (
	input logic        clk,
	input logic        arst_n,
	amnq_req_if.sink   req,
	amnq_res_if.source res
);
	import amnq_pkg::*;

	// usable vertex count is capped by the 4-bit vertex fields
	localparam int VCOUNT = (NUM_VERTICES < VTX_MAX) ? NUM_VERTICES : VTX_MAX;

	logic  push_valid;
	logic  push_ready;
	task_t push_data;
	logic  pop_valid;
	logic  pop_ready;
	task_t pop_data;

	amnq_front #(
		.VCOUNT(VCOUNT)
	) u_front (
		.req       (req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	amnq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	amnq_back #(
		.VCOUNT(VCOUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.res      (res)
	);

endmodule
